/* sv/icdl_pkg.sv */
// ----------------------------------------------------------------------------
// icdl_pkg
// Shared widths, command codes, control word layout and microprogram for the
// indexed circular doubly linked list engine.
// ----------------------------------------------------------------------------
package icdl_pkg;

    // node index space, fixed by the 10-bit node fields
    localparam int NODE_W    = 10;
    localparam int NUM_NODES = 1 << NODE_W;

    // default number of link sets
    localparam int LINK_SETS_DEF = 2;

    // stream payload widths
    localparam int MODE_W     = 3;
    localparam int S_TUSER_W  = MODE_W + 1;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // command modes
    localparam logic [MODE_W-1:0] MODE_INIT_HEAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IS_HEAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LINK_LIST = 3'd6;

    // link table access codes
    localparam logic [2:0] MEM_NONE    = 3'd0;
    localparam logic [2:0] MEM_RD_NEXT = 3'd1;
    localparam logic [2:0] MEM_RD_PREV = 3'd2;
    localparam logic [2:0] MEM_WR_NEXT = 3'd3;
    localparam logic [2:0] MEM_WR_PREV = 3'd4;

    // node source select for address and write data
    localparam logic [2:0] SEL_A  = 3'd0;
    localparam logic [2:0] SEL_B  = 3'd1;
    localparam logic [2:0] SEL_T  = 3'd2;
    localparam logic [2:0] SEL_U  = 3'd3;
    localparam logic [2:0] SEL_RD = 3'd4;

    // capture of the previous step's read data
    localparam logic [2:0] LD_NONE  = 3'd0;
    localparam logic [2:0] LD_T     = 3'd1;
    localparam logic [2:0] LD_U     = 3'd2;
    localparam logic [2:0] LD_RES   = 3'd3;
    localparam logic [2:0] LD_RES_T = 3'd4;
    localparam logic [2:0] LD_ALONE = 3'd5;

    // microprogram store
    localparam int PC_W = 5;

    // entry points of each command routine
    localparam logic [PC_W-1:0] E_INIT = 5'd0;
    localparam logic [PC_W-1:0] E_IS   = 5'd2;
    localparam logic [PC_W-1:0] E_PUSH = 5'd4;
    localparam logic [PC_W-1:0] E_POP  = 5'd9;
    localparam logic [PC_W-1:0] E_NEXT = 5'd13;
    localparam logic [PC_W-1:0] E_DEL  = 5'd15;
    localparam logic [PC_W-1:0] E_LINK = 5'd21;
    localparam logic [PC_W-1:0] E_NOP  = 5'd27;

    // one control word per step
    typedef struct packed {
        logic [2:0] mem;
        logic [2:0] asel;
        logic [2:0] dsel;
        logic [2:0] ld;
        logic       last;
    } ucode_t;

    // link table request kind
    typedef struct packed {
        logic rd;
        logic wr;
        logic is_next;
    } mem_cmd_t;

    function automatic ucode_t uw(logic [2:0] mem, logic [2:0] asel, logic [2:0] dsel,
                                  logic [2:0] ld, logic last);
        ucode_t w;
        w.mem  = mem;
        w.asel = asel;
        w.dsel = dsel;
        w.ld   = ld;
        w.last = last;
        return w;
    endfunction

    // dispatch from command mode to routine entry
    function automatic logic [PC_W-1:0] ucode_entry(logic [MODE_W-1:0] mode);
        logic [PC_W-1:0] e;
        case (mode)
            MODE_INIT_HEAD: e = E_INIT;
            MODE_IS_HEAD:   e = E_IS;
            MODE_PUSH_TAIL: e = E_PUSH;
            MODE_POP_TAIL:  e = E_POP;
            MODE_NEXT:      e = E_NEXT;
            MODE_DELETE:    e = E_DEL;
            MODE_LINK_LIST: e = E_LINK;
            default:        e = E_NOP;
        endcase
        return e;
    endfunction

    // microprogram: t, u are scratch nodes, rd is the last read data
    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            // init_head: next[a] = a, prev[a] = a
            5'd0:  w = uw(MEM_WR_NEXT, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd1:  w = uw(MEM_WR_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b1);
            // is_head: alone = prev[a] == a
            5'd2:  w = uw(MEM_RD_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd3:  w = uw(MEM_NONE,    SEL_A,  SEL_A,  LD_ALONE, 1'b1);
            // push_tail
            5'd4:  w = uw(MEM_RD_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd5:  w = uw(MEM_WR_PREV, SEL_B,  SEL_RD, LD_T,     1'b0);
            5'd6:  w = uw(MEM_WR_NEXT, SEL_B,  SEL_A,  LD_NONE,  1'b0);
            5'd7:  w = uw(MEM_WR_NEXT, SEL_T,  SEL_B,  LD_NONE,  1'b0);
            5'd8:  w = uw(MEM_WR_PREV, SEL_A,  SEL_B,  LD_NONE,  1'b1);
            // pop_tail
            5'd9:  w = uw(MEM_RD_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd10: w = uw(MEM_RD_PREV, SEL_RD, SEL_A,  LD_T,     1'b0);
            5'd11: w = uw(MEM_WR_PREV, SEL_A,  SEL_RD, LD_U,     1'b0);
            5'd12: w = uw(MEM_WR_NEXT, SEL_U,  SEL_A,  LD_RES_T, 1'b1);
            // next
            5'd13: w = uw(MEM_RD_NEXT, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd14: w = uw(MEM_NONE,    SEL_A,  SEL_A,  LD_RES,   1'b1);
            // delete
            5'd15: w = uw(MEM_RD_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd16: w = uw(MEM_RD_NEXT, SEL_A,  SEL_A,  LD_T,     1'b0);
            5'd17: w = uw(MEM_WR_NEXT, SEL_T,  SEL_RD, LD_U,     1'b0);
            5'd18: w = uw(MEM_WR_PREV, SEL_U,  SEL_T,  LD_NONE,  1'b0);
            5'd19: w = uw(MEM_WR_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd20: w = uw(MEM_WR_NEXT, SEL_A,  SEL_A,  LD_NONE,  1'b1);
            // link_list: splice list at a just after head b
            5'd21: w = uw(MEM_RD_PREV, SEL_A,  SEL_A,  LD_NONE,  1'b0);
            5'd22: w = uw(MEM_RD_NEXT, SEL_B,  SEL_A,  LD_T,     1'b0);
            5'd23: w = uw(MEM_WR_PREV, SEL_RD, SEL_T,  LD_U,     1'b0);
            5'd24: w = uw(MEM_WR_NEXT, SEL_T,  SEL_U,  LD_NONE,  1'b0);
            5'd25: w = uw(MEM_WR_NEXT, SEL_B,  SEL_A,  LD_NONE,  1'b0);
            5'd26: w = uw(MEM_WR_PREV, SEL_A,  SEL_B,  LD_NONE,  1'b1);
            // undefined mode and unused slots: finish with no access
            default: w = uw(MEM_NONE,  SEL_A,  SEL_A,  LD_NONE,  1'b1);
        endcase
        return w;
    endfunction

endpackage

/* sv/icdl_link_table.sv */
// ----------------------------------------------------------------------------
// icdl_link_table
// Next and prev link memories, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module icdl_link_table #(
    parameter int LINK_SETS = icdl_pkg::LINK_SETS_DEF,
    parameter int ADDR_W    = $clog2(LINK_SETS * icdl_pkg::NUM_NODES)
) (
    input  logic                        aclk,
    input  icdl_pkg::mem_cmd_t          cmd,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [icdl_pkg::NODE_W-1:0] wdata,
    output logic [icdl_pkg::NODE_W-1:0] rdata
);
    import icdl_pkg::*;

    localparam int DEPTH = LINK_SETS * NUM_NODES;

    logic [NODE_W-1:0] next_mem [DEPTH];
    logic [NODE_W-1:0] prev_mem [DEPTH];
    logic [NODE_W-1:0] next_rd_reg;
    logic [NODE_W-1:0] prev_rd_reg;
    logic              rd_next_reg;

    // next link memory
    always_ff @(posedge aclk) begin
        if (cmd.wr && cmd.is_next) begin
            next_mem[addr] <= wdata;
        end
        if (cmd.rd && cmd.is_next) begin
            next_rd_reg <= next_mem[addr];
        end
    end

    // prev link memory
    always_ff @(posedge aclk) begin
        if (cmd.wr && !cmd.is_next) begin
            prev_mem[addr] <= wdata;
        end
        if (cmd.rd && !cmd.is_next) begin
            prev_rd_reg <= prev_mem[addr];
        end
    end

    // remember which memory was read last
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_next_reg <= cmd.is_next;
        end
    end

    assign rdata = rd_next_reg ? next_rd_reg : prev_rd_reg;

endmodule

/* sv/indexed_circular_dlist_engine.sv */
// ----------------------------------------------------------------------------
// indexed_circular_dlist_engine
// Circular doubly linked lists kept in an indexed next/prev link table.
// ----------------------------------------------------------------------------
// Each command is one input transaction and gives exactly one result
// transaction. Commands run one at a time under a small microprogram that
// makes at most one link table access per step, so the table port sets the
// pace: a command is accepted, runs its steps, then hands over its result,
// and no new command is taken before that. A finished result waits in an
// output register, and the next command is accepted while it waits. Link
// entries hold no reset value: reading a node never written by init_head,
// push_tail, pop_tail, delete or link_list gives an unspecified node.
module indexed_circular_dlist_engine #(
    parameter int LINK_SETS = icdl_pkg::LINK_SETS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [icdl_pkg::S_TDATA_W-1:0] s_tdata,  // node_a[9:0], node_b[19:10], zero pad
    input  logic [icdl_pkg::S_TUSER_W-1:0] s_tuser,  // mode[2:0], link_set[3]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [icdl_pkg::M_TDATA_W-1:0] m_tdata   // node_out[9:0], alone[10], zero pad
);
    import icdl_pkg::*;

    localparam int SET_W  = (LINK_SETS > 1) ? $clog2(LINK_SETS) : 1;
    localparam int FULL_W = SET_W + NODE_W;
    localparam int TAB_AW = $clog2(LINK_SETS * NUM_NODES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg,     state_next;
    logic [PC_W-1:0]   pc_reg,        pc_next;
    logic [SET_W-1:0]  set_reg,       set_next;
    logic [NODE_W-1:0] a_reg,         a_next;
    logic [NODE_W-1:0] b_reg,         b_next;
    logic [NODE_W-1:0] t_reg,         t_next;
    logic [NODE_W-1:0] u_reg,         u_next;
    logic [NODE_W-1:0] res_reg,       res_next;
    logic              alone_reg,     alone_next;
    logic [NODE_W-1:0] out_node_reg,  out_node_next;
    logic              out_alone_reg, out_alone_next;
    logic              out_valid_reg, out_valid_next;

    ucode_t            uw_cur;
    mem_cmd_t          tab_cmd;
    logic [NODE_W-1:0] addr_node;
    logic [NODE_W-1:0] tab_wdata;
    logic [NODE_W-1:0] tab_rdata;
    logic [FULL_W-1:0] full_addr;
    logic [TAB_AW-1:0] tab_addr;
    logic              run;
    logic              out_free;

    // current control word
    assign uw_cur = ucode_rom(pc_reg);
    assign run    = (state_reg == ST_RUN);

    // address and write data selection
    always_comb begin
        case (uw_cur.asel)
            SEL_A:   addr_node = a_reg;
            SEL_B:   addr_node = b_reg;
            SEL_T:   addr_node = t_reg;
            SEL_U:   addr_node = u_reg;
            SEL_RD:  addr_node = tab_rdata;
            default: addr_node = a_reg;
        endcase
        case (uw_cur.dsel)
            SEL_A:   tab_wdata = a_reg;
            SEL_B:   tab_wdata = b_reg;
            SEL_T:   tab_wdata = t_reg;
            SEL_U:   tab_wdata = u_reg;
            SEL_RD:  tab_wdata = tab_rdata;
            default: tab_wdata = a_reg;
        endcase
    end

    assign full_addr = {set_reg, addr_node};
    assign tab_addr  = full_addr[TAB_AW-1:0];

    // link table request decode
    always_comb begin
        tab_cmd = '0;
        case (uw_cur.mem)
            MEM_RD_NEXT: begin
                tab_cmd.rd      = run;
                tab_cmd.is_next = 1'b1;
            end
            MEM_RD_PREV: begin
                tab_cmd.rd      = run;
            end
            MEM_WR_NEXT: begin
                tab_cmd.wr      = run;
                tab_cmd.is_next = 1'b1;
            end
            MEM_WR_PREV: begin
                tab_cmd.wr      = run;
            end
            default: begin
                tab_cmd = '0;
            end
        endcase
    end

    icdl_link_table #(
        .LINK_SETS (LINK_SETS),
        .ADDR_W    (TAB_AW)
    ) u_link_table (
        .aclk  (aclk),
        .cmd   (tab_cmd),
        .addr  (tab_addr),
        .wdata (tab_wdata),
        .rdata (tab_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;

    // sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        set_next       = set_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        res_next       = res_reg;
        alone_next     = alone_reg;
        out_node_next  = out_node_reg;
        out_alone_next = out_alone_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    set_next   = (LINK_SETS > 1) ? SET_W'(s_tuser[MODE_W]) : '0;
                    a_next     = s_tdata[NODE_W-1:0];
                    b_next     = s_tdata[2*NODE_W-1:NODE_W];
                    res_next   = '0;
                    alone_next = 1'b0;
                    pc_next    = ucode_entry(s_tuser[MODE_W-1:0]);
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // capture data read in the previous step
                case (uw_cur.ld)
                    LD_T:     t_next     = tab_rdata;
                    LD_U:     u_next     = tab_rdata;
                    LD_RES:   res_next   = tab_rdata;
                    LD_RES_T: res_next   = t_reg;
                    LD_ALONE: alone_next = (tab_rdata == a_reg);
                    default:  ;
                endcase
                if (uw_cur.last) begin
                    state_next = ST_DONE;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_node_next  = res_reg;
                    out_alone_next = alone_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
        set_reg       <= set_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        t_reg         <= t_next;
        u_reg         <= u_next;
        res_reg       <= res_next;
        alone_reg     <= alone_next;
        out_node_reg  <= out_node_next;
        out_alone_reg <= out_alone_next;
    end

    // stream outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - NODE_W - 1){1'b0}}, out_alone_reg, out_node_reg};

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the indexed circular doubly linked list engine.
// A short table of commands covers the corner cases (empty pop, lone heads,
// undefined mode, commands whose nodes coincide). Random command streams
// follow, most of them building and tearing down real lists. A link-table
// predictor gives the expected result of random commands and PRED rows,
// results are checked in order, and both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import icdl_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int SETS         = LINK_SETS_DEF;
    localparam int POOL         = 48;

    // mode code with no routine behind it
    localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;

    // directed rows either carry a typed-in result or take the predicted one
    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef logic [NODE_W-1:0] node_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              set;
        node_idx_t         a;
        node_idx_t         b;
    } list_cmd_t;

    typedef struct packed {
        node_idx_t node;
        logic      alone;
    } list_rsp_t;

    typedef struct packed {
        list_cmd_t cmd;
        logic      typed;
        list_rsp_t rsp;
    } table_row_t;

    typedef enum logic [1:0] {NODE_FREE, NODE_HEAD, NODE_MEMBER} node_role_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // node_a[9:0], node_b[19:10], zero pad
    logic [S_TUSER_W-1:0]   s_tuser  = '0;  // mode[2:0], link_set[3]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // node_out[9:0], alone[10], zero pad

    // link table copy kept by the predictor
    node_idx_t  next_of    [0:SETS-1][0:NUM_NODES-1];
    node_idx_t  prev_of    [0:SETS-1][0:NUM_NODES-1];
    bit         next_known [0:SETS-1][0:NUM_NODES-1];
    bit         prev_known [0:SETS-1][0:NUM_NODES-1];
    node_role_t role_of    [0:SETS-1][0:NUM_NODES-1];

    list_rsp_t  pending_results[$];
    list_rsp_t  oldest;
    int         fail_cnt      = 0;
    int         results_seen  = 0;
    int         cycle_count   = 0;
    int         burst_left    = 0;
    int         mode_count [0:7];
    int         hold_requests = 0;
    int         hold_taken    = 0;
    int         hold_left     = 0;
    int         pattern_age   = 0;
    logic [15:0] ready_pattern = 16'hffff;

    indexed_circular_dlist_engine #(
        .LINK_SETS(SETS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // link table writes, each marking the entry as defined
    function automatic void put_next(int s, node_idx_t n, node_idx_t v);
        next_of[s][n]    = v;
        next_known[s][n] = 1'b1;
    endfunction

    function automatic void put_prev(int s, node_idx_t n, node_idx_t v);
        prev_of[s][n]    = v;
        prev_known[s][n] = 1'b1;
    endfunction

    // apply one command to the link table copy and return its result
    function automatic list_rsp_t run_list_command(list_cmd_t c);
        list_rsp_t r;
        node_idx_t t;
        node_idx_t u;
        int        s;
        r = '0;
        s = c.set;
        case (c.mode)
            MODE_INIT_HEAD: begin
                put_next(s, c.a, c.a);
                put_prev(s, c.a, c.a);
            end
            MODE_IS_HEAD: begin
                r.alone = (prev_of[s][c.a] == c.a);
            end
            MODE_PUSH_TAIL: begin
                t = prev_of[s][c.a];
                put_prev(s, c.b, prev_of[s][c.a]);
                put_next(s, c.b, c.a);
                put_next(s, t, c.b);
                put_prev(s, c.a, c.b);
            end
            MODE_POP_TAIL: begin
                t = prev_of[s][c.a];
                u = prev_of[s][t];
                put_prev(s, c.a, u);
                put_next(s, u, c.a);
                r.node = t;
            end
            MODE_NEXT: begin
                r.node = next_of[s][c.a];
            end
            MODE_DELETE: begin
                t = prev_of[s][c.a];
                u = next_of[s][c.a];
                put_next(s, t, next_of[s][c.a]);
                put_prev(s, u, prev_of[s][c.a]);
                put_prev(s, c.a, c.a);
                put_next(s, c.a, c.a);
            end
            MODE_LINK_LIST: begin
                t = prev_of[s][c.a];
                u = next_of[s][c.b];
                put_prev(s, u, prev_of[s][c.a]);
                put_next(s, t, next_of[s][c.b]);
                put_next(s, c.b, c.a);
                put_prev(s, c.a, c.b);
            end
            default: ;
        endcase
        return r;
    endfunction

    // true when every entry the command reads has been written before
    function automatic bit touches_only_written(list_cmd_t c);
        int s;
        s = c.set;
        case (c.mode)
            MODE_IS_HEAD, MODE_PUSH_TAIL: return prev_known[s][c.a];
            MODE_POP_TAIL:  return prev_known[s][c.a] && prev_known[s][prev_of[s][c.a]];
            MODE_NEXT:      return next_known[s][c.a];
            MODE_DELETE:    return prev_known[s][c.a] && next_known[s][c.a];
            MODE_LINK_LIST: return prev_known[s][c.a] && next_known[s][c.b];
            default:        return 1'b1;
        endcase
    endfunction

    // rough bookkeeping of what each node is, used to steer the generator
    function automatic void update_roles(list_cmd_t c, list_rsp_t r);
        int s;
        s = c.set;
        case (c.mode)
            MODE_INIT_HEAD: role_of[s][c.a] = NODE_HEAD;
            MODE_PUSH_TAIL: if (c.b != c.a) role_of[s][c.b] = NODE_MEMBER;
            MODE_POP_TAIL:  if (r.node != c.a) role_of[s][r.node] = NODE_FREE;
            MODE_DELETE:    role_of[s][c.a] = NODE_FREE;
            MODE_LINK_LIST: if (c.b != c.a) role_of[s][c.a] = NODE_MEMBER;
            default: ;
        endcase
    endfunction

    // mostly low and high corners of the index space, sometimes anywhere
    function automatic node_idx_t pick_node();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(POOL - 1);
        else if (r < 85)
            return NUM_NODES - 1 - $urandom_range(POOL - 1);
        return $urandom_range(NUM_NODES - 1);
    endfunction

    function automatic bit find_node(int s, node_role_t want, output node_idx_t n);
        for (int i = 0; i < 64; i++) begin
            n = pick_node();
            if (role_of[s][n] == want) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic table_row_t dir_row(logic [MODE_W-1:0] mode, logic set,
                                           node_idx_t a, node_idx_t b, logic typed,
                                           node_idx_t node, logic alone);
        table_row_t row;
        row.cmd   = '{mode, set, a, b};
        row.typed = typed;
        row.rsp   = '{node, alone};
        return row;
    endfunction

    // list-shaped commands most of the time, raw noise otherwise
    task automatic make_random_command(output list_cmd_t c);
        int        s;
        int        op;
        bit        has_head;
        bit        has_free;
        node_idx_t hd;
        node_idx_t fr;
        node_idx_t other;
        s     = $urandom_range(SETS - 1);
        c.set = s;
        c.a   = pick_node();
        c.b   = $urandom_range(NUM_NODES - 1);
        if ($urandom_range(99) < 15) begin
            c.mode = $urandom_range(7);
            if ($urandom_range(1)) c.b = pick_node();
        end else begin
            has_head = find_node(s, NODE_HEAD, hd);
            has_free = find_node(s, NODE_FREE, fr);
            op       = $urandom_range(99);
            if (!has_head || op < 12) begin
                c.mode = MODE_INIT_HEAD;
                if (has_free) c.a = fr;
            end else if (op < 42) begin
                c.a = hd;
                if (has_free) begin
                    c.mode = MODE_PUSH_TAIL;
                    c.b    = fr;
                end else begin
                    c.mode = MODE_POP_TAIL;
                end
            end else if (op < 60) begin
                c.mode = MODE_POP_TAIL;
                c.a    = hd;
            end else if (op < 78) begin
                c.mode = (op < 70) ? MODE_NEXT : MODE_IS_HEAD;
                c.a    = hd;
                if (find_node(s, NODE_MEMBER, other)) c.a = other;
            end else if (op < 90) begin
                c.mode = MODE_POP_TAIL;
                c.a    = hd;
                if (find_node(s, NODE_MEMBER, other)) begin
                    c.mode = MODE_DELETE;
                    c.a    = other;
                end
            end else begin
                c.mode = MODE_NEXT;
                c.a    = hd;
                if (find_node(s, NODE_HEAD, other) && other != hd) begin
                    c.mode = MODE_LINK_LIST;
                    c.b    = other;
                end
            end
        end
        // never read an entry that holds no defined link yet
        if (!touches_only_written(c)) c.mode = MODE_INIT_HEAD;
    endtask

    // offer one transaction, with bursts and random gaps between them
    task automatic issue(list_cmd_t c, list_rsp_t want);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {{(S_TDATA_W - 2 * NODE_W){1'b0}}, c.b, c.a};
        s_tuser  <= {c.set, c.mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(want);
        mode_count[c.mode]++;
    endtask

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("mismatch at result %0d: %s expected %0d, got %0d",
                     results_seen, what, want, got);
    endtask

    // result side: in-order check, then next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with none pending, tdata", 0, m_tdata);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata[NODE_W-1:0] !== oldest.node)
                    flag_mismatch("node_out", oldest.node, m_tdata[NODE_W-1:0]);
                if (m_tdata[NODE_W] !== oldest.alone)
                    flag_mismatch("alone", oldest.alone, m_tdata[NODE_W]);
                if (m_tdata[M_TDATA_W-1:NODE_W+1] !== '0)
                    flag_mismatch("pad bits", 0, m_tdata[M_TDATA_W-1:NODE_W+1]);
            end
        end
        // long hold-off on request, otherwise a rotating ready pattern
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age = 128;
                case ($urandom_range(3))
                    0:       ready_pattern = 16'hffff;
                    1:       ready_pattern = $urandom & $urandom | 16'h0001;
                    default: ready_pattern = $urandom | 16'h0001;
                endcase
            end
            pattern_age--;
            m_tready      <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("** indexed_circular_dlist_engine: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial begin
        table_row_t rows[$];
        list_cmd_t  c;
        list_rsp_t  r;
        int         i;
        for (i = 0; i < SETS * NUM_NODES; i++)
            role_of[i / NUM_NODES][i % NUM_NODES] = NODE_FREE;
        for (i = 0; i < 8; i++)
            mode_count[i] = 0;

        // lone heads and the empty pop
        rows.push_back(dir_row(MODE_INIT_HEAD, 0, 0,    0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_IS_HEAD,   0, 0,    0,   TYPED, 0,    1));
        rows.push_back(dir_row(MODE_POP_TAIL,  0, 0,    0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_NEXT,      0, 0,    0,   TYPED, 0,    0));
        // build 1023 -> 0 -> 682 -> 341 in set 1, then take it apart
        rows.push_back(dir_row(MODE_INIT_HEAD, 1, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_IS_HEAD,   1, 1023, 0,   TYPED, 0,    1));
        rows.push_back(dir_row(MODE_PUSH_TAIL, 1, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_IS_HEAD,   1, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_NEXT,      1, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_PUSH_TAIL, 1, 1023, 682, TYPED, 0,    0));
        rows.push_back(dir_row(MODE_PUSH_TAIL, 1, 1023, 341, TYPED, 0,    0));
        rows.push_back(dir_row(MODE_POP_TAIL,  1, 1023, 0,   TYPED, 341,  0));
        rows.push_back(dir_row(MODE_NEXT,      0, 0,    0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_DELETE,    1, 0,    0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_NEXT,      1, 1023, 0,   TYPED, 682,  0));
        // splice list {1023, 1} behind head 0 in set 0
        rows.push_back(dir_row(MODE_INIT_HEAD, 0, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_PUSH_TAIL, 0, 1023, 1,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_LINK_LIST, 0, 1023, 0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_NEXT,      0, 0,    0,   TYPED, 1023, 0));
        rows.push_back(dir_row(MODE_POP_TAIL,  0, 0,    0,   TYPED, 1,    0));
        // undefined mode gives an all-zero result
        rows.push_back(dir_row(MODE_UNDEF,     1, 1023, 1023, TYPED, 0,   0));
        rows.push_back(dir_row(MODE_DELETE,    1, 682,  0,   TYPED, 0,    0));
        rows.push_back(dir_row(MODE_IS_HEAD,   1, 1023, 0,   TYPED, 0,    1));
        rows.push_back(dir_row(MODE_IS_HEAD,   1, 682,  0,   TYPED, 0,    1));
        // coinciding nodes: push a head onto itself, splice a list after itself
        rows.push_back(dir_row(MODE_PUSH_TAIL, 0, 0,    0,   PRED,  0,    0));
        rows.push_back(dir_row(MODE_LINK_LIST, 1, 1023, 1023, PRED, 0,    0));
        rows.push_back(dir_row(MODE_IS_HEAD,   0, 0,    0,   PRED,  0,    0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k]) begin
            r = run_list_command(rows[k].cmd);
            update_roles(rows[k].cmd, r);
            issue(rows[k].cmd, rows[k].typed ? rows[k].rsp : r);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // receiver holds off while commands keep coming
            if (i == RANDOM_ITEMS / 4)
                hold_requests++;
            // sender waits for the block to drain completely
            if (i == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            make_random_command(c);
            r = run_list_command(c);
            update_roles(c, r);
            issue(c, r);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d commands (%0d from the directed table), %0d results checked",
                 rows.size() + RANDOM_ITEMS, rows.size(), results_seen);
        $display("by kind: init %0d, is_head %0d, push %0d, pop %0d, next %0d, delete %0d, "
                 , mode_count[MODE_INIT_HEAD], mode_count[MODE_IS_HEAD],
                 mode_count[MODE_PUSH_TAIL], mode_count[MODE_POP_TAIL],
                 mode_count[MODE_NEXT], mode_count[MODE_DELETE],
                 "link %0d, undefined %0d; %0d mismatches",
                 mode_count[MODE_LINK_LIST], mode_count[MODE_UNDEF], fail_cnt);
        if (fail_cnt == 0) begin
            $display("** indexed_circular_dlist_engine: PASSED **");
        end else begin
            $display("** indexed_circular_dlist_engine: FAILED **");
        end
        $finish;
    end

endmodule
